// ----- hw/rtl/periodic_task_release_scheduler_assert.svh -----
// assertion macros shared by the release scheduler rtl
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PRTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prts assertion failed");

// next-cycle implication, checked outside reset
`define PRTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prts assertion failed");

`endif

// ----- hw/rtl/prts_pkg.sv -----
// types and constants for the periodic task release scheduler
package prts_pkg;

    localparam int NUM_CH    = 6;
    localparam int CH_IDX_W  = 3;
    localparam int CNT_W     = 11;
    localparam int PER_W     = 10;
    localparam int SHIFT_W   = 2;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 10;

    // register indexes beyond the per-channel periods
    localparam logic [REG_IDX_W-1:0] REG_COMMON_OFFSET = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_GAP_SHIFT     = 3'd7;

    // request codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [PER_W-1:0]   OFFSET_RESET = 10'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 2'd1;

    typedef logic [PER_W-1:0] period_arr_t [NUM_CH];

    localparam period_arr_t PERIOD_RESET = '{10'd2, 10'd10, 10'd20, 10'd50, 10'd200, 10'd1000};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_QUERY
    } state_t;

    typedef enum logic {
        OP_TICK,
        OP_GAP
    } op_t;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] cnt_next;
    } cmp_res_t;

endpackage

// ----- hw/rtl/prts_cmp_unit.sv -----
// shared add and compare unit for counter reloads and grant gap checks
module prts_cmp_unit #(
    parameter int W = 32
) (
    input  prts_pkg::op_t                    op,
    input  logic [prts_pkg::CNT_W-1:0]       cnt,
    input  logic [prts_pkg::PER_W-1:0]       period,
    input  logic [prts_pkg::PER_W-1:0]       offset,
    input  logic [prts_pkg::SHIFT_W-1:0]     shift,
    input  logic [W-1:0]                     now,
    input  logic [W-1:0]                     last,
    output prts_pkg::cmp_res_t               res
);
    import prts_pkg::*;

    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] limit;
    logic [W-1:0]     elapsed;
    logic [PER_W-1:0] gap;
    logic [W-1:0]     a_op;
    logic [W-1:0]     b_op;
    logic             ge;

    // tick side: incremented counter against period plus offset
    assign cnt_inc = cnt + {{(CNT_W-1){1'b0}}, 1'b1};
    assign limit   = {1'b0, period} + {1'b0, offset};

    // query side: wrapping elapsed ticks against the minimum gap
    assign elapsed = now - last;
    assign gap     = period >> shift;

    // one comparator serves both operations
    always_comb
    begin
        case (op)
            OP_TICK:
            begin
                a_op = {{(W-CNT_W){1'b0}}, cnt_inc};
                b_op = {{(W-CNT_W){1'b0}}, limit};
            end
            OP_GAP:
            begin
                a_op = elapsed;
                b_op = {{(W-PER_W){1'b0}}, gap};
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign ge = (a_op >= b_op);

    assign res.hit      = ge;
    assign res.cnt_next = ge ? {1'b0, offset} : cnt_inc;

endmodule

// ----- hw/rtl/periodic_task_release_scheduler.sv -----
// top level of the six-channel periodic task release scheduler
//
// input channel (in_valid/in_ready) carries req_type and task_id. a tick
// (req_type 0) advances the tick count and then visits the six channel
// counters one per cycle through a shared add/compare unit: in_ready drops
// for the walk, so no new tick or query is taken until it ends, and a tick
// gives no result. a query (req_type 1) reads the named channel in its
// compare step and checks its pending flag and the elapsed ticks since its
// last grant; granted lands in the output register when that step commits,
// and no new request is taken until then, as in_ready is high only in idle.
// output channel (out_valid/out_ready) holds granted until it is taken. if
// the receiver stalls with a result still waiting, a following query holds
// in its compare step until the output register frees, and no new input
// transfer is taken meanwhile.
// configuration writes (cfg_we/cfg_idx/cfg_wdata) take effect at once and
// are to be issued only while the block is idle.
// reset clears counters, flags, grant ticks and the tick count and loads
// the default periods, offset 0 and gap shift 1.
module periodic_task_release_scheduler #(
    parameter int TICK_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [2:0]                         task_id,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               granted,
    input  logic                               cfg_we,
    input  logic [prts_pkg::REG_IDX_W-1:0]     cfg_idx,
    input  logic [prts_pkg::CFG_W-1:0]         cfg_wdata
);
    import prts_pkg::*;

    state_t                  state_reg, state_next;
    logic [CH_IDX_W-1:0]     ch_idx_reg, ch_idx_next;
    logic [TICK_BITS-1:0]    now_tick_reg;
    logic                    out_valid_reg;
    logic                    granted_reg;

    logic [PER_W-1:0]        period_reg [NUM_CH];
    logic [PER_W-1:0]        offset_reg;
    logic [SHIFT_W-1:0]      shift_reg;

    logic [CNT_W-1:0]        cnt_reg  [NUM_CH];
    logic [TICK_BITS-1:0]    last_reg [NUM_CH];
    logic [NUM_CH-1:0]       pend_reg;

    logic                    in_xfer;
    logic                    out_xfer;
    logic                    in_range;
    logic [CH_IDX_W-1:0]     rd_idx;
    op_t                     op;
    cmp_res_t                cmp_res;
    logic                    tick_upd;
    logic                    commit;
    logic                    grant_now;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // channel select, guarded for the out-of-range ids
    assign in_range = (ch_idx_reg < CH_IDX_W'(NUM_CH));
    assign rd_idx   = in_range ? ch_idx_reg : '0;
    assign op       = (state_reg == ST_TICK) ? OP_TICK : OP_GAP;

    prts_cmp_unit #(
        .W (TICK_BITS)
    ) u_cmp (
        .op     (op),
        .cnt    (cnt_reg[rd_idx]),
        .period (period_reg[rd_idx]),
        .offset (offset_reg),
        .shift  (shift_reg),
        .now    (now_tick_reg),
        .last   (last_reg[rd_idx]),
        .res    (cmp_res)
    );

    assign tick_upd  = (state_reg == ST_TICK);
    assign commit    = (state_reg == ST_QUERY) && (!out_valid_reg || out_ready);
    assign grant_now = in_range && pend_reg[rd_idx] && cmp_res.hit;

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        ch_idx_next = ch_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (req_type == REQ_TICK)
                    begin
                        state_next  = ST_TICK;
                        ch_idx_next = '0;
                    end
                    else
                    begin
                        state_next  = ST_QUERY;
                        ch_idx_next = task_id;
                    end
                end
            end
            ST_TICK:
            begin
                if (ch_idx_reg == CH_IDX_W'(NUM_CH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ch_idx_next = ch_idx_reg + 1'b1;
                end
            end
            ST_QUERY:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers and tick count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ch_idx_reg   <= '0;
            now_tick_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ch_idx_reg <= ch_idx_next;
            if (in_xfer && (req_type == REQ_TICK))
            begin
                now_tick_reg <= now_tick_reg + 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                period_reg[i] <= PERIOD_RESET[i];
            end
            offset_reg <= OFFSET_RESET;
            shift_reg  <= SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx < REG_IDX_W'(NUM_CH))
            begin
                period_reg[cfg_idx] <= cfg_wdata[PER_W-1:0];
            end
            else if (cfg_idx == REG_COMMON_OFFSET)
            begin
                offset_reg <= cfg_wdata[PER_W-1:0];
            end
            else if (cfg_idx == REG_GAP_SHIFT)
            begin
                shift_reg <= cfg_wdata[SHIFT_W-1:0];
            end
        end
    end

    // channel state: counters, pending flags, last grant ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                cnt_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
            pend_reg <= '0;
        end
        else if (tick_upd)
        begin
            cnt_reg[rd_idx] <= cmp_res.cnt_next;
            if (cmp_res.hit)
            begin
                pend_reg[rd_idx] <= 1'b1;
            end
        end
        else if (commit && grant_now)
        begin
            pend_reg[rd_idx] <= 1'b0;
            last_reg[rd_idx] <= now_tick_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            granted_reg   <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
            granted_reg   <= grant_now;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;

    `include "periodic_task_release_scheduler_assert.svh"

    // a tick transfer advances the tick count by one and starts the walk at channel 0
    `PRTS_ASSERT_NXT(a_tick_advance, in_xfer && (req_type == REQ_TICK), (now_tick_reg == $past(now_tick_reg) + 1'b1) && (state_reg == ST_TICK) && (ch_idx_reg == '0))
    // the channel walk never steps past the last channel
    `PRTS_ASSERT_IMP(a_walk_range, state_reg == ST_TICK, ch_idx_reg < CH_IDX_W'(NUM_CH))
    // an out-of-range channel never grants
    `PRTS_ASSERT_NXT(a_no_grant_oor, commit && !in_range, out_valid_reg && !granted_reg)
    // a grant clears the channel's pending flag
    `PRTS_ASSERT_NXT(a_grant_clears, commit && grant_now, pend_reg[$past(rd_idx)] == 1'b0)

endmodule

// ----- bench/tb_periodic_task_release_scheduler.sv -----
// self-checking testbench for the six-channel periodic task release scheduler
`timescale 1ns / 1ps

module tb_periodic_task_release_scheduler;
    import prts_pkg::*;

    // narrow tick count
    localparam int TB_TICK_BITS  = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int USE_MODEL     = -1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 req_type = REQ_TICK;
    logic [2:0]           task_id = 3'd0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 granted;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    periodic_task_release_scheduler #(
        .TICK_BITS(TB_TICK_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .task_id   (task_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .granted   (granted),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // release scheduler state kept by the bench
    logic [CNT_W-1:0]        release_counter [NUM_CH];
    logic                    release_pending [NUM_CH];
    logic [TB_TICK_BITS-1:0] last_grant_at   [NUM_CH];
    logic [TB_TICK_BITS-1:0] tick_now;
    period_arr_t             period_cfg;
    logic [PER_W-1:0]        offset_cfg;
    logic [SHIFT_W-1:0]      shift_cfg;

    logic grant_expect [$];
    logic grant_head;

    int errors        = 0;
    int ticks_sent    = 0;
    int queries_sent  = 0;
    int grants_seen   = 0;
    int results_seen  = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int stall_left    = 0;
    int stall_pct     = 0;
    bit gaps_on       = 1'b1;

    typedef struct {
        logic       kind;
        logic [2:0] id;
        int         typed_grant;
    } row_t;

    // reset defaults: ch0 releases every 2 ticks, ch1 every 10, others later
    row_t directed_rows [25] = '{
        '{REQ_QUERY, 3'd0, 0},
        '{REQ_QUERY, 3'd5, 0},
        '{REQ_QUERY, 3'd6, 0},
        '{REQ_QUERY, 3'd7, 0},
        '{REQ_TICK,  3'd0, USE_MODEL},
        '{REQ_TICK,  3'd7, USE_MODEL},
        '{REQ_QUERY, 3'd0, USE_MODEL},
        '{REQ_QUERY, 3'd0, 0},
        '{REQ_QUERY, 3'd6, 0},
        '{REQ_TICK,  3'd3, USE_MODEL},
        '{REQ_TICK,  3'd4, USE_MODEL},
        '{REQ_QUERY, 3'd0, USE_MODEL},
        '{REQ_TICK,  3'd0, USE_MODEL},
        '{REQ_TICK,  3'd1, USE_MODEL},
        '{REQ_TICK,  3'd2, USE_MODEL},
        '{REQ_TICK,  3'd5, USE_MODEL},
        '{REQ_TICK,  3'd6, USE_MODEL},
        '{REQ_TICK,  3'd7, USE_MODEL},
        '{REQ_QUERY, 3'd1, USE_MODEL},
        '{REQ_QUERY, 3'd1, 0},
        '{REQ_QUERY, 3'd0, USE_MODEL},
        '{REQ_QUERY, 3'd2, 0},
        '{REQ_QUERY, 3'd3, 0},
        '{REQ_QUERY, 3'd4, 0},
        '{REQ_QUERY, 3'd7, 0}
    };

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch at %0t: %s got %b expected %b", $time, what, got, want);
        errors++;
    endtask

    // one tick: tick count first, then every channel counter
    function automatic void advance_tick();
        logic [CNT_W-1:0] next_cnt;
        logic [CNT_W-1:0] limit;
        tick_now = tick_now + 1'b1;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            next_cnt = release_counter[ch] + 1'b1;
            limit    = {1'b0, period_cfg[ch]} + {1'b0, offset_cfg};
            if (next_cnt >= limit)
            begin
                release_pending[ch] = 1'b1;
                next_cnt            = {1'b0, offset_cfg};
            end
            release_counter[ch] = next_cnt;
        end
    endfunction

    // grant decision for one query, with its side effects
    function automatic logic decide_grant(input logic [2:0] id);
        logic [TB_TICK_BITS-1:0] elapsed;
        logic [PER_W-1:0]        min_gap;
        if (id >= NUM_CH)
            return 1'b0;
        if (!release_pending[id])
            return 1'b0;
        elapsed = tick_now - last_grant_at[id];
        min_gap = period_cfg[id] >> shift_cfg;
        if (elapsed < min_gap)
            return 1'b0;
        last_grant_at[id]   = tick_now;
        release_pending[id] = 1'b0;
        return 1'b1;
    endfunction

    // present one item and hold it until the transfer
    task automatic send_item(input logic kind, input logic [2:0] id, input int typed_grant);
        logic g;
        in_valid <= 1'b1;
        req_type <= kind;
        task_id  <= id;
        do @(posedge clk); while (!in_ready);
        if (kind == REQ_TICK)
        begin
            advance_tick();
            ticks_sent++;
        end
        else
        begin
            g = decide_grant(id);
            grant_expect.push_back((typed_grant == USE_MODEL) ? g : typed_grant[0]);
            queries_sent++;
        end
    endtask

    task automatic hold_off(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // sender stops until every pending grant decision has come back
    task automatic wait_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (grant_expect.size() != 0);
    endtask

    // idle the block fully: results back and any tick walk finished
    task automatic drain();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx < NUM_CH)
            period_cfg[idx] = data[PER_W-1:0];
        else if (idx == REG_COMMON_OFFSET)
            offset_cfg = data[PER_W-1:0];
        else if (idx == REG_GAP_SHIFT)
            shift_cfg = data[SHIFT_W-1:0];
    endtask

    task automatic apply_settings(input period_arr_t per, input logic [PER_W-1:0] off,
                                  input logic [SHIFT_W-1:0] sh);
        logic [CFG_W-1:0] shift_word;
        drain();
        for (int ch = 0; ch < NUM_CH; ch++)
            cfg_write(REG_IDX_W'(ch), per[ch]);
        cfg_write(REG_COMMON_OFFSET, off);
        // upper bits of the shift write are don't-care
        shift_word = CFG_W'($urandom_range(0, 1023));
        shift_word[SHIFT_W-1:0] = sh;
        cfg_write(REG_GAP_SHIFT, shift_word);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // bursts of transfers separated by random gaps
    task automatic next_slot();
        if (burst_left == 0)
        begin
            if (gaps_on)
                hold_off($urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic run_phase(input int n_items, input int tick_pct);
        logic [2:0] id;
        for (int i = 0; i < n_items; i++)
        begin
            next_slot();
            if (i == n_items / 2 || $urandom_range(0, 199) == 0)
                wait_results();
            if ($urandom_range(0, 99) < tick_pct)
            begin
                id = 3'($urandom_range(0, 7));
                send_item(REQ_TICK, id, USE_MODEL);
            end
            else
            begin
                id = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                    : $urandom_range(0, 5));
                send_item(REQ_QUERY, id, USE_MODEL);
            end
        end
    endtask

    // receiver stalls in runs of random length
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
                stall_left <= $urandom_range(1, 7);
        end
    end

    // check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grant_expect.size() == 0)
                report_mismatch("unexpected result, granted", granted, 1'b0);
            else
            begin
                grant_head = grant_expect.pop_front();
                if (granted !== grant_head)
                    report_mismatch("granted", granted, grant_head);
                if (granted === 1'b1)
                    grants_seen++;
                results_seen++;
            end
        end
    end

    initial
    begin
        #30000000;
        $display("timeout at %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        period_arr_t per;

        // bench state at reset
        period_cfg = PERIOD_RESET;
        offset_cfg = OFFSET_RESET;
        shift_cfg  = SHIFT_RESET;
        tick_now   = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            release_counter[ch] = '0;
            release_pending[ch] = 1'b0;
            last_grant_at[ch]   = '0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset settings, receiver always ready
        gaps_on = 1'b0;
        foreach (directed_rows[r])
            send_item(directed_rows[r].kind, directed_rows[r].id, directed_rows[r].typed_grant);

        // smallest settings: release on every tick, minimum gap of one tick
        stall_pct <= 20;
        gaps_on = 1'b1;
        per = '{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1};
        apply_settings(per, 10'd0, 2'd0);
        run_phase(150, 50);

        // largest settings: 11-bit threshold of 2046, counters climb without release
        stall_pct <= 40;
        per = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023};
        apply_settings(per, 10'd1023, 2'd3);
        run_phase(400, 97);

        // zero periods on channels 0, 1 and 5: threshold there is the offset alone
        stall_pct <= 0;
        per = '{10'd0, 10'd0, 10'd3, 10'd1, 10'd7, 10'd0};
        apply_settings(per, PER_W'($urandom_range(0, 5)), SHIFT_W'($urandom_range(0, 3)));
        run_phase(150, 55);

        // random settings, mostly short periods so releases are frequent
        for (int p = 0; p < 5; p++)
        begin
            stall_pct <= $urandom_range(0, 60);
            gaps_on = (p != 2);
            for (int ch = 0; ch < NUM_CH; ch++)
                per[ch] = PER_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                              : $urandom_range(1, 24));
            apply_settings(per, PER_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                                   : $urandom_range(0, 8)),
                           SHIFT_W'($urandom_range(0, 3)));
            run_phase(130, 60);
        end

        drain();
        $display("covered %0d ticks and %0d queries over %0d register settings",
                 ticks_sent, queries_sent, settings_used);
        $display("%0d results checked, %0d grants, tick count held on %0d bits",
                 results_seen, grants_seen, TB_TICK_BITS);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
